@@ rtl/lfnc_pkg.sv @@
// ============================================================================
// lfnc_pkg
// Shared types and constants for the line follower navigation controller:
// transaction payloads, navigation modes, motor commands, route codes.
// ============================================================================
package lfnc_pkg;

  localparam int NUM_SENSORS = 5;
  localparam int SAMPLE_BITS = 13;
  localparam int CH_W        = 3;
  localparam int THRESH_W    = 13;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(500);

  // Sensor channel positions
  localparam int CH_FL = 0;
  localparam int CH_FR = 1;
  localparam int CH_CL = 2;
  localparam int CH_CR = 3;

  typedef enum logic [2:0] {
    MODE_FWD   = 3'd0,
    MODE_PASS  = 3'd1,
    MODE_LEFT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_STOP  = 3'd4
  } nav_mode_t;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_FWD     = 4'd1,
    CMD_NUDGE_L = 4'd2,
    CMD_NUDGE_R = 4'd3,
    CMD_TURN_L  = 4'd4,
    CMD_TURN_R  = 4'd5,
    CMD_STOP    = 4'd6,
    CMD_UNIT    = 4'd7,
    CMD_ROTATE  = 4'd8
  } motor_cmd_t;

  typedef enum logic [2:0] {
    INSTR_LEFT   = 3'd0,
    INSTR_RIGHT  = 3'd1,
    INSTR_PASS   = 3'd2,
    INSTR_TURN   = 3'd3,
    INSTR_UNIT   = 3'd4,
    INSTR_NONE   = 3'd5
  } route_instr_t;

  typedef struct packed {
    logic [CH_W-1:0]        sensor_channel;
    logic [SAMPLE_BITS-1:0] sample_mv;
    logic                   period_end;
    logic [2:0]             route_instruction;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             motor_command;
    logic                   advance_route;
    logic [NUM_SENSORS-1:0] sensor_bits;
    logic [2:0]             nav_mode;
  } out_item_t;

endpackage

@@ rtl/line_follower_navigation_controller.sv @@
// ============================================================================
// line_follower_navigation_controller
// Pipeline: an accepted transaction passes the input register (s1), the
//   update stage and the output register (two-register pipeline).
// Throughput: one transaction per cycle while the output is not stalled;
//   the single update stage between the two registers sets this figure.
// Reset (rst_n low, synchronous): peaks cleared, all sensors on, mode forward,
//   threshold 500 mV, both pipeline registers empty.
// ============================================================================
module line_follower_navigation_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample transactions
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfnc_pkg::in_item_t   in_data,
  // result transactions
  output logic                 out_valid,
  input  logic                 out_ready,
  output lfnc_pkg::out_item_t  out_data,
  // threshold register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [lfnc_pkg::THRESH_W-1:0] cfg_data
);

  import lfnc_pkg::*;

  // --------------------------------------------------------------------------
  // Pipeline control: input register (s1) feeds the update stage, which
  // loads the output register. Advance both whenever the output slot is free
  // or being drained.
  // --------------------------------------------------------------------------
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      adv_en;
  logic      upd_en;
  logic      in_fire;

  assign adv_en   = !out_valid_r || out_ready;
  assign upd_en   = s1_valid_r && adv_en;
  assign in_ready = !s1_valid_r || adv_en;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // cfg_ready is tied high; the user writes the threshold only while idle.
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv_en) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv_en ? s1_valid_r : out_valid_r;
  end

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  logic [THRESH_W-1:0]                       thresh_r;
  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0]   period_peak_r, period_peak_nxt;
  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0]   past_peak_r, past_peak_nxt;
  logic [NUM_SENSORS-1:0]                    sensor_on_r, sensor_on_nxt;
  nav_mode_t                                 nav_state_r, nav_state_nxt;

  // --------------------------------------------------------------------------
  // Update stage, operating on the transaction held in s1
  // --------------------------------------------------------------------------
  logic                                      ch_valid;
  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0]   peak_upd;
  logic [NUM_SENSORS-1:0]                    ch_hit;
  logic                                      pend;
  logic                                      left_en;
  logic                                      right_en;
  logic                                      instr_unit;
  logic                                      instr_turn;
  motor_cmd_t                                cmd;
  logic                                      adv;

  assign ch_valid = s1_data_r.sensor_channel < CH_W'(NUM_SENSORS);
  assign pend     = s1_data_r.period_end;

  // Fold the sample into its channel's running peak, then roll the peaks
  // into the past values when this transaction closes the period.
  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      ch_hit[i] = ch_valid && (s1_data_r.sensor_channel == CH_W'(i));
      peak_upd[i] = (ch_hit[i] && (s1_data_r.sample_mv > period_peak_r[i])) ?
                    s1_data_r.sample_mv : period_peak_r[i];
    end
    if (pend) begin
      past_peak_nxt   = peak_upd;
      period_peak_nxt = '0;
    end else begin
      past_peak_nxt   = past_peak_r;
      period_peak_nxt = peak_upd;
    end
  end

  // Sensor bit of the sampled channel follows its (possibly just rolled) past
  // peak against the threshold; the other bits hold.
  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sensor_on_nxt[i] = ch_hit[i] ? (past_peak_nxt[i] >= SAMPLE_BITS'(thresh_r))
                                   : sensor_on_r[i];
    end
  end

  // Route decoding. Unit step and turn around finish the period on their own
  // and leave the state machine alone; unknown codes disable both turns.
  always_comb begin
    instr_unit = 1'b0;
    instr_turn = 1'b0;
    left_en    = 1'b0;
    right_en   = 1'b0;
    unique case (s1_data_r.route_instruction)
      INSTR_LEFT:  left_en    = 1'b1;
      INSTR_RIGHT: right_en   = 1'b1;
      INSTR_TURN:  instr_turn = 1'b1;
      INSTR_UNIT:  instr_unit = 1'b1;
      INSTR_PASS, INSTR_NONE: ;
      default: ;
    endcase
  end

  // Navigation next state; uses the sensor bits from before this update.
  always_comb begin
    nav_state_nxt = nav_state_r;
    if (pend && !instr_unit && !instr_turn) begin
      unique case (nav_state_r)
        MODE_PASS: begin
          if (sensor_on_r[CH_CL] && sensor_on_r[CH_CR]) begin
            nav_state_nxt = MODE_FWD;
          end
        end
        MODE_LEFT, MODE_RIGHT: nav_state_nxt = MODE_FWD;
        MODE_FWD: begin
          priority if (sensor_on_r == '0) begin
            nav_state_nxt = MODE_STOP;
          end else if (!(sensor_on_r[CH_FL] && sensor_on_r[CH_FR]) &&
                       !left_en && !right_en) begin
            nav_state_nxt = MODE_PASS;
          end else if (!sensor_on_r[CH_FL] && left_en) begin
            nav_state_nxt = MODE_LEFT;
          end else if (!sensor_on_r[CH_FR] && right_en) begin
            nav_state_nxt = MODE_RIGHT;
          end else begin
            nav_state_nxt = MODE_FWD;
          end
        end
        MODE_STOP: begin
          if (sensor_on_r != '0) begin
            nav_state_nxt = MODE_FWD;
          end
        end
        default: nav_state_nxt = nav_state_r;
      endcase
    end
  end

  // Motor command and route advance pulse.
  always_comb begin
    cmd = CMD_NONE;
    adv = 1'b0;
    if (pend) begin
      priority if (instr_unit) begin
        cmd = CMD_UNIT;
        adv = 1'b1;
      end else if (instr_turn) begin
        cmd = CMD_ROTATE;
        adv = 1'b1;
      end else begin
        unique case (nav_state_r)
          MODE_PASS: begin
            cmd = CMD_FWD;
            adv = sensor_on_r[CH_CL] && sensor_on_r[CH_CR];
          end
          MODE_LEFT: begin
            cmd = CMD_TURN_L;
            adv = 1'b1;
          end
          MODE_RIGHT: begin
            cmd = CMD_TURN_R;
            adv = 1'b1;
          end
          MODE_FWD: begin
            // Mode changes out of forward issue no command this period.
            priority if (sensor_on_r == '0) begin
              cmd = CMD_NONE;
            end else if (!(sensor_on_r[CH_FL] && sensor_on_r[CH_FR]) &&
                         !left_en && !right_en) begin
              cmd = CMD_NONE;
            end else if (!sensor_on_r[CH_FL] && left_en) begin
              cmd = CMD_NONE;
            end else if (!sensor_on_r[CH_FR] && right_en) begin
              cmd = CMD_NONE;
            end else if (!sensor_on_r[CH_CL]) begin
              cmd = CMD_NUDGE_L;
            end else if (!sensor_on_r[CH_CR]) begin
              cmd = CMD_NUDGE_R;
            end else begin
              cmd = CMD_FWD;
            end
          end
          MODE_STOP: cmd = CMD_STOP;
          default:   cmd = CMD_NONE;
        endcase
      end
    end
  end

  always_comb begin
    out_data_nxt.motor_command = cmd;
    out_data_nxt.advance_route = adv;
    out_data_nxt.sensor_bits   = sensor_on_nxt;
    out_data_nxt.nav_mode      = nav_state_nxt;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      thresh_r      <= THRESH_RESET;
      period_peak_r <= '0;
      past_peak_r   <= '0;
      sensor_on_r   <= '1;
      nav_state_r   <= MODE_FWD;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
      // Commit state only as the transaction moves into the output register.
      if (upd_en) begin
        period_peak_r <= period_peak_nxt;
        past_peak_r   <= past_peak_nxt;
        sensor_on_r   <= sensor_on_nxt;
        nav_state_r   <= nav_state_nxt;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (upd_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Without a period end, no command and no route advance.
  a_quiet_mid_period: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && !s1_data_r.period_end) |=>
      (out_data_r.motor_command == CMD_NONE && !out_data_r.advance_route))
    else $error("command issued without period end");

  // Navigation state holds between period ends.
  a_nav_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && !s1_data_r.period_end) |=> $stable(nav_state_r))
    else $error("navigation state moved mid period");

  // Running peaks restart from zero after a period end.
  a_peaks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && s1_data_r.period_end) |=> (period_peak_r == '0))
    else $error("period peaks not cleared");

  // Reported mode and sensor bits match the committed state.
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> (out_data_r.nav_mode == nav_state_r &&
                out_data_r.sensor_bits == sensor_on_r))
    else $error("result disagrees with committed state");

endmodule

@@ sim/line_follower_navigation_controller_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// line_follower_navigation_controller_tb
// Self-checking bench: drives sensor sample transactions with bursty timing,
// stalls the result side on its own pattern, predicts every result from a
// behavioral copy of the peak/sensor/navigation state, and checks in order.
// ============================================================================
module line_follower_navigation_controller_tb;
  import lfnc_pkg::*;

  localparam int           CLK_HALF    = 5;
  localparam int           STALL_LIMIT = 4000;
  localparam int           LONG_HOLD   = 250;
  localparam int           PHASE_ITEMS = 220;
  localparam int           MAX_MV      = (1 << SAMPLE_BITS) - 1;
  localparam int           CH_BC       = 4;
  localparam int           CH_BAD_LO   = 5;
  localparam int           CH_BAD_HI   = 7;
  // Route codes beyond the defined set; the block treats them as "none"
  localparam logic [2:0]   INSTR_SPARE6 = 3'd6;
  localparam logic [2:0]   INSTR_SPARE7 = 3'd7;
  localparam int           NUM_CMDS     = 9;
  localparam int           IN_W         = $bits(in_item_t);

  // --------------------------------------------------------------------------
  // Predicted navigation results, held in acceptance order
  // --------------------------------------------------------------------------
  class nav_result_board;
    logic [SAMPLE_BITS-1:0] period_peak [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] past_peak   [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] sensor_on;
    nav_mode_t              nav;
    logic                   left_en;
    logic                   right_en;
    logic [THRESH_W-1:0]    on_threshold;
    out_item_t              expected_results [$];
    int unsigned            failures;
    int unsigned            results_seen;
    int unsigned            cmd_hits [NUM_CMDS];

    function new();
      for (int i = 0; i < NUM_SENSORS; i++) begin
        period_peak[i] = '0;
        past_peak[i]   = '0;
      end
      sensor_on    = '1;
      nav          = MODE_FWD;
      left_en      = 1'b1;
      right_en     = 1'b1;
      on_threshold = THRESH_RESET;
      failures     = 0;
      results_seen = 0;
      for (int i = 0; i < NUM_CMDS; i++) cmd_hits[i] = 0;
    endfunction

    function void set_threshold(logic [THRESH_W-1:0] v);
      on_threshold = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the state by one accepted sample and queue its result
    function void predict_sample(in_item_t it);
      logic [CH_W-1:0]        ch;
      logic [SAMPLE_BITS-1:0] mv;
      logic [2:0]             ins;
      logic                   in_range;
      motor_cmd_t             cmd;
      logic                   adv;
      out_item_t              res;
      ch       = it.sensor_channel;
      mv       = it.sample_mv;
      ins      = it.route_instruction;
      in_range = (ch < NUM_SENSORS);
      cmd      = CMD_NONE;
      adv      = 1'b0;

      if (in_range && mv > period_peak[ch]) period_peak[ch] = mv;

      if (it.period_end) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          past_peak[i]   = period_peak[i];
          period_peak[i] = '0;
        end
        if (ins == INSTR_UNIT) begin
          cmd = CMD_UNIT;
          adv = 1'b1;
        end else if (ins == INSTR_TURN) begin
          cmd = CMD_ROTATE;
          adv = 1'b1;
        end else begin
          left_en  = (ins == INSTR_LEFT);
          right_en = (ins == INSTR_RIGHT);
          case (nav)
            MODE_PASS: begin
              if (sensor_on[CH_CL] && sensor_on[CH_CR]) begin
                adv = 1'b1;
                nav = MODE_FWD;
              end
              cmd = CMD_FWD;
            end
            MODE_LEFT: begin
              cmd = CMD_TURN_L;
              adv = 1'b1;
              nav = MODE_FWD;
            end
            MODE_RIGHT: begin
              cmd = CMD_TURN_R;
              adv = 1'b1;
              nav = MODE_FWD;
            end
            MODE_FWD: begin
              if (sensor_on == '0) nav = MODE_STOP;
              else if (!(sensor_on[CH_FL] && sensor_on[CH_FR]) && !left_en && !right_en)
                nav = MODE_PASS;
              else if (!sensor_on[CH_FL] && left_en) nav = MODE_LEFT;
              else if (!sensor_on[CH_FR] && right_en) nav = MODE_RIGHT;
              else if (!sensor_on[CH_CL]) cmd = CMD_NUDGE_L;
              else if (!sensor_on[CH_CR]) cmd = CMD_NUDGE_R;
              else cmd = CMD_FWD;
            end
            default: begin
              cmd = CMD_STOP;
              if (sensor_on != '0) nav = MODE_FWD;
            end
          endcase
        end
      end

      if (in_range) sensor_on[ch] = (past_peak[ch] >= on_threshold);

      res.motor_command = cmd;
      res.advance_route = adv;
      res.sensor_bits   = sensor_on;
      res.nav_mode      = nav;
      expected_results.push_back(res);
      cmd_hits[int'(cmd)]++;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result cmd=%0d adv=%0b bits=%05b mode=%0d",
                               got.motor_command, got.advance_route,
                               got.sensor_bits, got.nav_mode));
        return;
      end
      want = expected_results.pop_front();
      if (got.motor_command !== want.motor_command ||
          got.advance_route !== want.advance_route ||
          got.sensor_bits   !== want.sensor_bits   ||
          got.nav_mode      !== want.nav_mode)
        note_failure($sformatf(
          "result %0d exp cmd=%0d adv=%0b bits=%05b mode=%0d got cmd=%0d adv=%0b bits=%05b mode=%0d",
          results_seen, want.motor_command, want.advance_route, want.sensor_bits,
          want.nav_mode, got.motor_command, got.advance_route, got.sensor_bits,
          got.nav_mode));
    endfunction

    function void flush_leftovers();
      while (expected_results.size() != 0) begin
        void'(expected_results.pop_front());
        note_failure("expected result never arrived");
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_data;

  always #(CLK_HALF) clk = ~clk;

  line_follower_navigation_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  nav_result_board     board;
  logic [THRESH_W-1:0] threshold_now;
  int unsigned         samples_sent;
  int unsigned         threshold_writes;
  int unsigned         burst_left;
  int unsigned         stall_cycles;
  bit                  no_gaps;
  bit                  hold_req;

  // --------------------------------------------------------------------------
  // Result monitor: every accepted result transaction goes to the checker.
  // Sampled at the rising edge, before any register of the block updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which no channel moves a transaction. A hang
  // anywhere (sender blocked, result never produced) ends the run here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               stall_cycles, board.pending());
      $display("FAIL line_follower_navigation_controller");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, changed at the falling edge.
  // Segments alternate between always ready, mostly ready, mostly stalled and
  // a periodic pattern. On request, hold off for a long stretch so the block
  // fills up and pushes back on the sender.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned seg_left;
    mode      = 0;
    seg_left  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = ($urandom_range(0, 9) < 7);
          2:       out_ready = ($urandom_range(0, 9) < 3);
          default: out_ready = (seg_left % 4 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. All drive changes happen at the falling edge; each task
  // returns at a falling edge so back-to-back transactions keep valid high.
  // --------------------------------------------------------------------------

  // Offer one sample transaction; open a new burst (maybe after a gap) when
  // the current one is spent. Hold valid and payload until accepted.
  task automatic offer_sample(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0 && !no_gaps) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.predict_sample(it);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic push_sample(input int ch, input int mv, input bit pe,
                             input logic [2:0] ins);
    in_item_t it;
    it.sensor_channel    = CH_W'(ch);
    it.sample_mv         = SAMPLE_BITS'(mv);
    it.period_end        = pe;
    it.route_instruction = ins;
    offer_sample(it);
  endtask

  // Drop valid and wait for every predicted result to come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Write the threshold; only called with the block idle
  task automatic write_threshold(input logic [THRESH_W-1:0] v);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_threshold(v);
    threshold_now = v;
    threshold_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sample value on the requested side of the current threshold, 1 in 8 random
  function automatic int pick_level(input bit high);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, MAX_MV);
    if (high) return $urandom_range(int'(threshold_now), MAX_MV);
    if (threshold_now == 0) return 0;
    return $urandom_range(0, int'(threshold_now) - 1);
  endfunction

  // Random traffic shaped as sensing periods: a handful of samples with a
  // planned on/off level per channel, closed by a period-end transaction
  // carrying a route instruction. Sprinkle in out-of-range channels, spare
  // route codes and fully random transactions as noise.
  task automatic run_periods(input int unsigned count);
    int unsigned done;
    int unsigned p_high;
    int unsigned k;
    int unsigned r;
    int          ch;
    bit          level [NUM_SENSORS];
    in_item_t    it;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 2))
        0:       p_high = 10;
        1:       p_high = 50;
        default: p_high = 90;
      endcase
      for (int i = 0; i < NUM_SENSORS; i++) level[i] = ($urandom_range(0, 99) < p_high);
      k = $urandom_range(2, 9);
      for (int j = 0; j < k; j++) begin
        ch = ($urandom_range(0, 15) == 0) ? $urandom_range(CH_BAD_LO, CH_BAD_HI)
                                          : $urandom_range(0, NUM_SENSORS - 1);
        push_sample(ch, pick_level(ch < NUM_SENSORS ? level[ch] : 1'b1), 1'b0,
                    3'($urandom_range(0, 7)));
      end
      ch = ($urandom_range(0, 9) == 0) ? $urandom_range(CH_BAD_LO, CH_BAD_HI)
                                       : $urandom_range(0, NUM_SENSORS - 1);
      r = $urandom_range(0, 19);
      push_sample(ch, pick_level(ch < NUM_SENSORS ? level[ch] : 1'b1), 1'b1,
                  (r < 18) ? 3'(r % 6) : ((r == 18) ? INSTR_SPARE6 : INSTR_SPARE7));
      done += k + 1;
      if ($urandom_range(0, 9) == 0) begin
        it = in_item_t'(IN_W'($urandom));
        offer_sample(it);
        done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [THRESH_W-1:0] thresholds [4];
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    no_gaps          = 1'b0;
    hold_req         = 1'b0;
    burst_left       = 0;
    samples_sent     = 0;
    threshold_writes = 0;
    threshold_now    = THRESH_RESET;
    board            = new();

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: field extremes, every route code, out-of-range channels, the
    // unit-step and turn-around period ends, and walks through the forward
    // and pass-junction modes from the reset state.
    push_sample(CH_FL,  MAX_MV, 1'b0, INSTR_NONE);
    push_sample(CH_FR,  0,      1'b1, INSTR_NONE);
    push_sample(CH_BAD_HI, MAX_MV, 1'b1, INSTR_SPARE7);
    push_sample(CH_CL,  0,      1'b1, INSTR_PASS);
    push_sample(CH_CR,  100,    1'b1, INSTR_LEFT);
    push_sample(CH_FL,  0,      1'b1, INSTR_RIGHT);
    push_sample(CH_BC,  0,      1'b1, INSTR_NONE);
    push_sample(CH_BAD_LO, MAX_MV, 1'b1, INSTR_SPARE6);
    push_sample(6,      0,      1'b1, INSTR_NONE);
    push_sample(CH_CL,  MAX_MV, 1'b0, INSTR_LEFT);
    push_sample(CH_FL,  600,    1'b1, INSTR_UNIT);
    push_sample(CH_CL,  0,      1'b1, INSTR_NONE);
    push_sample(CH_BC,  499,    1'b0, INSTR_PASS);
    push_sample(CH_BC,  500,    1'b1, INSTR_TURN);
    push_sample(CH_CR,  MAX_MV, 1'b0, INSTR_RIGHT);
    push_sample(CH_BC,  MAX_MV, 1'b1, INSTR_NONE);
    push_sample(CH_FL,  0,      1'b1, INSTR_LEFT);
    push_sample(CH_FR,  MAX_MV, 1'b1, INSTR_LEFT);
    push_sample(CH_FL,  MAX_MV, 1'b1, INSTR_LEFT);
    push_sample(CH_CR,  0,      1'b1, INSTR_NONE);
    push_sample(CH_FR,  4096,   1'b0, INSTR_SPARE7);
    push_sample(CH_CL,  MAX_MV, 1'b1, INSTR_SPARE6);
    push_sample(CH_CR,  MAX_MV, 1'b1, INSTR_RIGHT);
    push_sample(CH_CR,  2730,   1'b1, INSTR_PASS);

    // Random traffic at the reset threshold, then at each further setting
    run_periods(PHASE_ITEMS);

    thresholds[0] = '0;
    thresholds[1] = THRESH_W'(MAX_MV);
    thresholds[2] = THRESH_W'($urandom_range(1, MAX_MV - 1));
    thresholds[3] = THRESH_W'(1);
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thresholds[ph]);
      if (ph == 1) begin
        // Long receiver hold-off while the sender keeps offering: the
        // pipeline fills and in_ready must drop.
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        run_periods(40);
        no_gaps  = 1'b0;
        run_periods(PHASE_ITEMS - 40);
      end else if (ph == 2) begin
        // Sender pauses mid-phase until every result is back
        run_periods(PHASE_ITEMS / 2);
        drain_results();
        run_periods(PHASE_ITEMS / 2);
      end else begin
        run_periods(PHASE_ITEMS);
      end
    end

    // Wind down: wait for outstanding results, keep waiting to catch any
    // stray result, then close out leftovers.
    drain_results();
    repeat (8) @(negedge clk);
    board.flush_leftovers();

    $display("Covered %0d samples, %0d results, %0d threshold writes, %0d failures.",
             samples_sent, board.results_seen, threshold_writes, board.failures);
    $display("Commands: none %0d fwd %0d nudge %0d/%0d turn %0d/%0d stop %0d unit %0d rot %0d",
             board.cmd_hits[CMD_NONE], board.cmd_hits[CMD_FWD],
             board.cmd_hits[CMD_NUDGE_L], board.cmd_hits[CMD_NUDGE_R],
             board.cmd_hits[CMD_TURN_L], board.cmd_hits[CMD_TURN_R],
             board.cmd_hits[CMD_STOP], board.cmd_hits[CMD_UNIT],
             board.cmd_hits[CMD_ROTATE]);
    if (board.failures == 0) begin
      $display("PASS line_follower_navigation_controller");
    end else begin
      $display("FAIL line_follower_navigation_controller");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lfnc_pkg.sv
rtl/line_follower_navigation_controller.sv
sim/line_follower_navigation_controller_tb.sv
